// ===== design/rnsp_pkg.sv =====
// Shared types and constants of the radix number string parser.
package rnsp_pkg;

    // Widths of the payload fields
    localparam int CHAR_W   = 8;
    localparam int RADIX_W  = 6;
    localparam int DCHAR_W  = 7;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 6;

    // Radix after reset
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

    // Characters with a meaning of their own
    localparam logic [CHAR_W-1:0] CH_NUL        = 8'h00;
    localparam logic [CHAR_W-1:0] CH_PLUS       = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_COMMA      = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_MINUS      = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PERIOD     = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE       = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 8'h7A;

    // Distance from lowercase to uppercase letters
    localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;
    // Digit value of the letter A
    localparam logic [CHAR_W-1:0] LETTER_BASE = 8'd10;

    // Completion status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_FIRST = 2'd1,
        ST_BAD_DIGIT = 2'd2,
        ST_NO_DIGITS = 2'd3
    } status_t;

    // Parser phase, one-hot
    typedef enum logic [3:0] {
        PH_START   = 4'b0001,
        PH_PREFIX  = 4'b0010,
        PH_DIGITS  = 4'b0100,
        PH_DISCARD = 4'b1000
    } phase_t;

    // Per-literal parser state
    typedef struct packed {
        phase_t phase;
        logic   negative;
        logic   zero_pending;
        logic   digit_seen;
    } parse_state_t;

    localparam parse_state_t STATE_CLEAR = '{
        phase: PH_START, negative: 1'b0, zero_pending: 1'b0, digit_seen: 1'b0
    };

    // One result word
    typedef struct packed {
        logic                neg_sign;
        status_t             status;
        logic                number_done;
        logic [DCHAR_W-1:0]  digit_char;
        logic                digit_valid;
    } result_t;

endpackage

// ===== design/rnsp_step.sv =====
// Next-state and result logic for one character of the literal.
module rnsp_step import rnsp_pkg::*; (
    input  logic [CHAR_W-1:0]  in_char,
    input  logic [RADIX_W-1:0] radix,
    input  parse_state_t       state,
    output parse_state_t       state_next,
    output logic               res_valid,
    output result_t            res
);

    logic               is_dec;
    logic               is_upper;
    logic               is_lower;
    logic               is_sign;
    logic [CHAR_W-1:0]  value_wide;
    logic [VALUE_W-1:0] value;
    logic               digit_ok;
    logic [CHAR_W-1:0]  upper_char;

    // Classify the character and take its digit value
    always_comb begin
        is_dec   = (in_char >= CH_ZERO) && (in_char <= CH_NINE);
        is_upper = (in_char >= CH_UPPER_A) && (in_char <= CH_UPPER_Z);
        is_lower = (in_char >= CH_LOWER_A) && (in_char <= CH_LOWER_Z);
        is_sign  = (in_char == CH_MINUS) || (in_char == CH_PLUS);
        if (is_dec) begin
            value_wide = in_char - CH_ZERO;
        end else if (is_upper) begin
            value_wide = in_char - CH_UPPER_A + LETTER_BASE;
        end else begin
            value_wide = in_char - CH_LOWER_A + LETTER_BASE;
        end
        value      = value_wide[VALUE_W-1:0];
        digit_ok   = (is_dec || is_upper || is_lower) && (value < radix);
        upper_char = is_lower ? (in_char - CASE_OFFSET) : in_char;
    end

    // Walk the phases
    always_comb begin
        logic stage;
        stage      = 1'b0;
        state_next = state;
        res_valid  = 1'b0;
        res        = '0;

        case (state.phase)
            PH_START: begin
                if (is_sign) begin
                    state_next.negative = (in_char == CH_MINUS);
                    state_next.phase    = PH_PREFIX;
                end else if (is_dec) begin
                    state_next.phase = PH_PREFIX;
                    if (in_char == CH_ZERO) begin
                        state_next.zero_pending = 1'b1;
                    end else begin
                        stage = 1'b1;
                    end
                end else begin
                    state_next       = STATE_CLEAR;
                    state_next.phase = (in_char == CH_NUL) ? PH_START : PH_DISCARD;
                    res_valid        = 1'b1;
                    res.number_done  = 1'b1;
                    res.status       = ST_BAD_FIRST;
                end
            end
            PH_PREFIX: begin
                if (!state.zero_pending && is_sign) begin
                    if (in_char == CH_MINUS) begin
                        state_next.negative = !state.negative;
                    end
                end else if (in_char == CH_ZERO) begin
                    state_next.zero_pending = 1'b1;
                end else if ((in_char == CH_NUL) && state.zero_pending) begin
                    // Only zeros reached the end: keep one zero
                    state_next      = STATE_CLEAR;
                    res_valid       = 1'b1;
                    res.digit_valid = 1'b1;
                    res.digit_char  = CH_ZERO[DCHAR_W-1:0];
                    res.number_done = 1'b1;
                    res.status      = ST_OK;
                    res.neg_sign    = state.negative;
                end else begin
                    stage = 1'b1;
                end
            end
            PH_DIGITS: begin
                stage = 1'b1;
            end
            PH_DISCARD: begin
                if (in_char == CH_NUL) begin
                    state_next = STATE_CLEAR;
                end
            end
            default: begin
                state_next = STATE_CLEAR;
            end
        endcase

        // Digit stage, shared by the first three phases
        if (stage) begin
            state_next.phase        = PH_DIGITS;
            state_next.zero_pending = 1'b0;
            if ((in_char == CH_NUL) || (in_char == CH_PERIOD)) begin
                state_next       = STATE_CLEAR;
                state_next.phase = (in_char == CH_NUL) ? PH_START : PH_DISCARD;
                res_valid        = 1'b1;
                res.number_done  = 1'b1;
                res.status       = state.digit_seen ? ST_OK : ST_NO_DIGITS;
                res.neg_sign     = state.negative;
            end else if ((in_char == CH_UNDERSCORE) || (in_char == CH_COMMA)) begin
                res_valid = 1'b0;
            end else if (!digit_ok) begin
                state_next       = STATE_CLEAR;
                state_next.phase = PH_DISCARD;
                res_valid        = 1'b1;
                res.number_done  = 1'b1;
                res.status       = ST_BAD_DIGIT;
                res.neg_sign     = state.negative;
            end else begin
                state_next.digit_seen = 1'b1;
                res_valid             = 1'b1;
                res.digit_valid       = 1'b1;
                res.digit_char        = upper_char[DCHAR_W-1:0];
            end
        end
    end

endmodule

// ===== design/radix_number_string_parser_core.sv =====
// Top level of the radix number string parser: registers, handshakes, assertions.
//
// Streaming parser of a signed integer literal, one ASCII character per input
// word, NUL-terminated. Each character passes an input register and is parsed
// into the result register once that register can take it, so the block
// takes one word per clock unless m_tready stalls the full result. A character
// yields either no result (signs, leading zeros, separators, discarded input)
// or one result word: an accepted digit as uppercase '0'-'9'/'A'-'Z', or the
// closing word with tlast high, a status (0 ok, 1 bad first character,
// 2 invalid digit, 3 no digits) and the sign. A closing word that was not
// caused by a NUL makes the parser drop input up to and including the next
// NUL. The radix is to be written through cfg_ only while the block is idle;
// the block itself does not enforce this; cfg_ready is always high.
module radix_number_string_parser_core import rnsp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    // Radix write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [RADIX_W-1:0] cfg_data,
    // Character input
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [CHAR_W-1:0]  s_tdata,   // [7:0] in_char
    // Result output
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // [0] digit_valid, [7:1] digit_char
    output logic               m_tlast,   // number_done
    output logic [2:0]         m_tuser    // [1:0] status, [2] neg_sign
);

    logic [RADIX_W-1:0] radix_reg;
    logic               in_valid_reg;
    logic [CHAR_W-1:0]  in_char_reg;
    parse_state_t       state_reg;
    parse_state_t       state_next;
    logic               out_valid_reg;
    result_t            out_reg;
    logic               res_valid;
    result_t            res;
    logic               advance;

    assign cfg_ready = 1'b1;

    // Hold the radix
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= RADIX_RESET;
        end else if (cfg_valid) begin
            radix_reg <= cfg_data;
        end
    end

    // Parse the held word once the result register can take its result
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Capture the input word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata;
        end
    end

    rnsp_step u_step (
        .in_char    (in_char_reg),
        .radix      (radix_reg),
        .state      (state_reg),
        .state_next (state_next),
        .res_valid  (res_valid),
        .res        (res)
    );

    // Advance the parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_CLEAR;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Load or drain the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.digit_char, out_reg.digit_valid};
    assign m_tlast  = out_reg.number_done;
    assign m_tuser  = {out_reg.neg_sign, out_reg.status};

`ifndef NO_ASSERTIONS
    // A word without tlast is always a plain digit
    a_digit_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> (m_tdata[0] && (m_tuser == 3'd0)))
        else $error("non-final result word carries no digit");

    // Emitted digits are uppercase base-36 characters
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |->
            (((m_tdata[7:1] >= CH_ZERO[DCHAR_W-1:0]) && (m_tdata[7:1] <= CH_NINE[DCHAR_W-1:0]))
          || ((m_tdata[7:1] >= CH_UPPER_A[DCHAR_W-1:0])
              && (m_tdata[7:1] <= CH_UPPER_Z[DCHAR_W-1:0]))))
        else $error("digit character out of range");

    // Flags live only in their phases
    a_flag_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (!state_reg.digit_seen || (state_reg.phase == PH_DIGITS))
        && (!state_reg.zero_pending || (state_reg.phase == PH_PREFIX)))
        else $error("parser flag set outside its phase");

    // Input stalls only behind a stalled full result register
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (out_valid_reg && !m_tready && in_valid_reg))
        else $error("input stalled without back pressure");
`endif

endmodule

// ===== verif/rnsp_checker.sv =====
`timescale 1ns / 1ps
// Checker for the radix number string parser: predicts result words and compares them.
module rnsp_checker import rnsp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [RADIX_W-1:0] cfg_data,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [CHAR_W-1:0]  s_tdata,
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [7:0]         m_tdata,
    input  logic               m_tlast,
    input  logic [2:0]         m_tuser,
    output int                 fail_count,
    output int                 pending
);

    // Predicted parser state and radix
    logic [RADIX_W-1:0] radix;
    parse_state_t       lit;
    result_t            owed_words[$];

    result_t            want;
    result_t            seen;
    bit                 produced;

    // Weight of an alphanumeric character, -1 for anything else
    function automatic int char_weight(input logic [CHAR_W-1:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c - CH_ZERO);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            return int'(c - CH_UPPER_A) + int'(LETTER_BASE);
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            return int'(c - CH_LOWER_A) + int'(LETTER_BASE);
        return -1;
    endfunction

    // Build the closing word and return to a fresh literal in the given phase
    task automatic close_literal(input status_t st, input phase_t next_phase,
                                 output result_t r);
        r = '0;
        r.number_done = 1'b1;
        r.status      = st;
        r.neg_sign    = lit.negative;
        lit           = STATE_CLEAR;
        lit.phase     = next_phase;
    endtask

    // Handle a character once the digit part has begun
    task automatic take_digit_char(input logic [CHAR_W-1:0] c, output bit got,
                                   output result_t r);
        int w;
        got              = 1'b0;
        r                = '0;
        lit.phase        = PH_DIGITS;
        lit.zero_pending = 1'b0;
        if (c == CH_NUL) begin
            got = 1'b1;
            close_literal(lit.digit_seen ? ST_OK : ST_NO_DIGITS, PH_START, r);
        end else if (c == CH_PERIOD) begin
            got = 1'b1;
            close_literal(lit.digit_seen ? ST_OK : ST_NO_DIGITS, PH_DISCARD, r);
        end else if (c != CH_UNDERSCORE && c != CH_COMMA) begin
            got = 1'b1;
            w   = char_weight(c);
            if (w < 0 || w >= int'(radix)) begin
                close_literal(ST_BAD_DIGIT, PH_DISCARD, r);
            end else begin
                lit.digit_seen = 1'b1;
                r.digit_valid  = 1'b1;
                r.digit_char   = (w < 10) ? DCHAR_W'(int'(CH_ZERO) + w)
                                          : DCHAR_W'(int'(CH_UPPER_A) + w - 10);
            end
        end
    endtask

    // Advance the predicted parser by one character
    task automatic parse_char(input logic [CHAR_W-1:0] c, output bit got,
                              output result_t r);
        got = 1'b0;
        r   = '0;
        case (lit.phase)
            PH_START: begin
                if (c == CH_MINUS || c == CH_PLUS) begin
                    lit.negative = (c == CH_MINUS);
                    lit.phase    = PH_PREFIX;
                end else if (c >= CH_ZERO && c <= CH_NINE) begin
                    lit.phase = PH_PREFIX;
                    if (c == CH_ZERO)
                        lit.zero_pending = 1'b1;
                    else
                        take_digit_char(c, got, r);
                end else begin
                    got = 1'b1;
                    close_literal(ST_BAD_FIRST, (c == CH_NUL) ? PH_START : PH_DISCARD, r);
                    r.neg_sign = 1'b0;
                end
            end
            PH_PREFIX: begin
                if (!lit.zero_pending && (c == CH_MINUS || c == CH_PLUS)) begin
                    if (c == CH_MINUS)
                        lit.negative = !lit.negative;
                end else if (c == CH_ZERO) begin
                    lit.zero_pending = 1'b1;
                end else if (c == CH_NUL && lit.zero_pending) begin
                    // Only zeros: keep a single zero digit on the closing word
                    got = 1'b1;
                    close_literal(ST_OK, PH_START, r);
                    r.digit_valid = 1'b1;
                    r.digit_char  = DCHAR_W'(CH_ZERO);
                end else begin
                    take_digit_char(c, got, r);
                end
            end
            PH_DIGITS: begin
                take_digit_char(c, got, r);
            end
            default: begin
                // Drop input up to the terminator
                if (c == CH_NUL)
                    lit = STATE_CLEAR;
            end
        endcase
    endtask

    // Report one wrong field
    task automatic flag_field(input string name, input int exp_val, input int act_val);
        $display("%0t: %s expected %0d, actual %0d", $time, name, exp_val, act_val);
        fail_count++;
    endtask

    // Track radix writes, compare result words, predict from accepted characters
    always @(posedge aclk) begin
        if (!aresetn) begin
            radix      = RADIX_RESET;
            lit        = STATE_CLEAR;
            owed_words.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                radix = cfg_data;

            if (m_tvalid && m_tready) begin
                seen = {m_tuser, m_tlast, m_tdata};
                if (owed_words.size() == 0) begin
                    $display("%0t: expected no word, actual %h", $time, seen);
                    fail_count++;
                end else begin
                    want = owed_words.pop_front();
                    if (seen.digit_valid !== want.digit_valid)
                        flag_field("digit_valid", want.digit_valid, seen.digit_valid);
                    if (seen.digit_char !== want.digit_char)
                        flag_field("digit_char", want.digit_char, seen.digit_char);
                    if (seen.number_done !== want.number_done)
                        flag_field("number_done", want.number_done, seen.number_done);
                    if (seen.status !== want.status)
                        flag_field("status", want.status, seen.status);
                    if (seen.neg_sign !== want.neg_sign)
                        flag_field("neg_sign", want.neg_sign, seen.neg_sign);
                end
            end

            if (s_tvalid && s_tready) begin
                parse_char(s_tdata, produced, want);
                if (produced)
                    owed_words.push_back(want);
            end
        end
        pending = owed_words.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the radix number string parser: clock, reset, stimulus, verdict.
module tb import rnsp_pkg::*; ();

    localparam int IDLE_LIMIT        = 2000;
    localparam int SETTLE_CYCLES     = 4;
    localparam int DRAIN_CYCLES      = 8;
    localparam int ITEMS_PER_SETTING = 185;
    localparam int NUM_SETTINGS      = 10;
    localparam int NUM_DIRECTED      = 26;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [RADIX_W-1:0] cfg_data  = '0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [CHAR_W-1:0]  s_tdata   = '0;
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [7:0]         m_tdata;
    logic               m_tlast;
    logic [2:0]         m_tuser;

    int                 fail_count;
    int                 pending;
    int                 chars_sent  = 0;
    int                 cur_radix   = 10;
    int                 stall_left  = 0;
    int                 idle_cycles = 0;
    bit                 calm        = 1'b0;

    // Radix settings, extremes and out-of-range values among them
    logic [RADIX_W-1:0] radix_plan [0:NUM_SETTINGS-1] =
        '{6'd2, 6'd36, 6'd16, 6'd0, 6'd1, 6'd37, 6'd63, 6'd8, 6'd10, 6'd36};

    // Opening literals at the reset radix of ten
    logic [CHAR_W-1:0] directed_chars [0:NUM_DIRECTED-1] = '{
        // lone zero
        CH_ZERO, CH_NUL,
        // sign toggling, then one digit
        CH_PLUS, CH_MINUS, CH_ZERO + 8'd7, CH_NUL,
        // bad first character, then discard
        CH_LOWER_A + 8'd23, CH_NUL,
        // terminator as the first character
        CH_NUL,
        // sign after a dropped zero
        CH_ZERO, CH_MINUS, CH_NUL,
        // separators, period, discarded tail
        CH_ZERO + 8'd1, CH_UNDERSCORE, CH_ZERO + 8'd2, CH_COMMA, CH_PERIOD,
        CH_NINE, CH_NUL,
        // zeros ended by a period
        CH_ZERO, CH_ZERO, CH_PERIOD, CH_NUL,
        // negative literal with a non-ASCII character
        CH_MINUS, 8'hFF, CH_NUL
    };

    radix_number_string_parser_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    rnsp_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 4 ns clock
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // Gap length: mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 19) < 17)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // A character whose weight is below lim (any base-36 weight when lim is zero), random letter case
    function automatic logic [CHAR_W-1:0] pick_digit_char(input int lim);
        int w;
        w = (lim == 0) ? $urandom_range(0, 35) : $urandom_range(0, lim - 1);
        if (w < 10)
            return CH_ZERO + CHAR_W'(w);
        if ($urandom_range(0, 1))
            return CH_UPPER_A + CHAR_W'(w - 10);
        return CH_LOWER_A + CHAR_W'(w - 10);
    endfunction

    // Offer one character word, holding it until accepted
    task automatic send_char(input logic [CHAR_W-1:0] c);
        int gap;
        gap = (calm || $urandom_range(0, 1)) ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
        chars_sent++;
    endtask

    // One random literal: mostly well formed, some noise or a corrupt character
    task automatic send_literal();
        int kind;
        int lim;
        int n;
        int bad_pos;
        kind = $urandom_range(0, 9);
        lim  = (cur_radix > 36) ? 36 : cur_radix;
        if (kind == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) send_char(CHAR_W'($urandom_range(0, 255)));
            send_char(CH_NUL);
            return;
        end
        // leading signs
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) send_char($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        // leading zeros
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        repeat (n) send_char(CH_ZERO);
        // digit body with separators
        n       = $urandom_range(0, 8);
        bad_pos = (kind == 1) ? $urandom_range(0, n) : -1;
        for (int i = 0; i <= n; i++) begin
            if (i == bad_pos)
                send_char(CHAR_W'($urandom_range(1, 255)));
            if (i == n)
                break;
            if ($urandom_range(0, 7) == 0)
                send_char($urandom_range(0, 1) ? CH_UNDERSCORE : CH_COMMA);
            else
                send_char(pick_digit_char(lim));
        end
        // terminator, sometimes after a fraction that gets dropped
        if ($urandom_range(0, 5) == 0) begin
            send_char(CH_PERIOD);
            n = $urandom_range(0, 3);
            repeat (n) send_char(CHAR_W'($urandom_range(1, 255)));
        end
        send_char(CH_NUL);
    endtask

    // Stop offering, wait for all owed words and the pipeline to empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write the radix register
    task automatic write_radix(input logic [RADIX_W-1:0] r);
        cfg_valid <= 1'b1;
        cfg_data  <= r;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cur_radix = int'(r);
    endtask

    // Result side: random stalls, with calm stretches of none
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 9) < 6) begin
            m_tready <= 1'b1;
        end else begin
            stall_left = pick_gap() - 1;
            m_tready <= 1'b0;
        end
    end

    // Watchdog on cycles without any accepted word
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Reset, directed literals, then random literals under each radix
    initial begin
        int setting_end;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_char(directed_chars[i]);

        for (int k = 0; k < NUM_SETTINGS; k++) begin
            settle();
            write_radix(radix_plan[k]);
            calm        = ($urandom_range(0, 3) == 0);
            setting_end = chars_sent + ITEMS_PER_SETTING;
            while (chars_sent < setting_end) send_literal();
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
